/* rtl/bfr_pkg.sv */
// Shared types, constants and helpers for the binary frame receiver.
package bfr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 512;
  localparam int CFG_IDX_W         = 8;
  localparam int INDEX_W           = 9;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h81;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(1);

  // Known message ids, in kind-code order 1..7
  localparam logic [15:0] ID_KIND1 = 16'd3000;
  localparam logic [15:0] ID_KIND2 = 16'd3001;
  localparam logic [15:0] ID_KIND3 = 16'd3011;
  localparam logic [15:0] ID_KIND4 = 16'd3002;
  localparam logic [15:0] ID_KIND5 = 16'd3003;
  localparam logic [15:0] ID_KIND6 = 16'd3006;
  localparam logic [15:0] ID_KIND7 = 16'd2200;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;

  typedef enum logic [11:0] {
    PH_SYNC1    = 12'b0000_0000_0001,
    PH_SYNC2    = 12'b0000_0000_0010,
    PH_ID_LO    = 12'b0000_0000_0100,
    PH_ID_HI    = 12'b0000_0000_1000,
    PH_LEN_LO   = 12'b0000_0001_0000,
    PH_LEN_HI   = 12'b0000_0010_0000,
    PH_SPARE_LO = 12'b0000_0100_0000,
    PH_SPARE_HI = 12'b0000_1000_0000,
    PH_CHK_LO   = 12'b0001_0000_0000,
    PH_CHK_HI   = 12'b0010_0000_0000,
    PH_PAYLOAD  = 12'b0100_0000_0000,
    PH_TRAILER  = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic               payload_strobe;
    logic [7:0]         payload_byte;
    logic [INDEX_W-1:0] payload_index;
    logic               frame_done;
    logic               header_good;
    logic [2:0]         message_kind;
    logic [15:0]        message_id;
    logic [15:0]        word_count;
  } result_t;

  function automatic logic [2:0] kind_of(input logic [15:0] id);
    logic [2:0] k;
    case (id)
      ID_KIND1: k = 3'd1;
      ID_KIND2: k = 3'd2;
      ID_KIND3: k = 3'd3;
      ID_KIND4: k = 3'd4;
      ID_KIND5: k = 3'd5;
      ID_KIND6: k = 3'd6;
      ID_KIND7: k = 3'd7;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

/* rtl/bfr_ifs.sv */
// Channel interfaces: received bytes, result items and configuration writes.
interface bfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bfr_res_if;
  logic        valid;
  logic        ready;
  logic        payload_strobe;
  logic [7:0]  payload_byte;
  logic [8:0]  payload_index;
  logic        frame_done;
  logic        header_good;
  logic [2:0]  message_kind;
  logic [15:0] message_id;
  logic [15:0] word_count;
  modport source (output valid, output payload_strobe, output payload_byte,
                  output payload_index, output frame_done, output header_good,
                  output message_kind, output message_id, output word_count,
                  input ready);
  modport sink   (input valid, input payload_strobe, input payload_byte,
                  input payload_index, input frame_done, input header_good,
                  input message_kind, input message_id, input word_count,
                  output ready);
endinterface

interface bfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bfr_parser.sv */
// Frame parsing state machine: header capture, payload indexing, header check.
module bfr_parser import bfr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  output result_t    res
);

  localparam int POS_W = $clog2(PAYLOAD_BYTES);

  phase_t           phase, phase_next;
  logic [15:0]      id_word, id_word_next;
  logic [15:0]      length_word, length_word_next;
  logic [15:0]      spare_word, spare_word_next;
  logic [15:0]      check_word, check_word_next;
  logic [POS_W-1:0] pos, pos_next;

  logic [POS_W:0]   pos_inc;
  logic [POS_W-1:0] pos_wrap;
  logic             in_payload;
  logic [15:0]      hdr_sum;
  logic             good;

  assign pos_inc    = {1'b0, pos} + 1'b1;
  assign pos_wrap   = (pos_inc >= (POS_W+1)'(PAYLOAD_BYTES)) ? '0 : pos_inc[POS_W-1:0];
  assign in_payload = 17'(pos) < {length_word, 1'b0};
  // check word plus sum of the other header words is zero when it is their negation
  assign hdr_sum    = {sync_second, sync_first} + id_word + length_word + spare_word
                      + check_word;
  assign good       = (hdr_sum == 16'd0);

  always_comb begin
    phase_next       = phase;
    id_word_next     = id_word;
    length_word_next = length_word;
    spare_word_next  = spare_word;
    check_word_next  = check_word;
    pos_next         = pos;
    res              = '0;
    case (phase)
      PH_SYNC1: begin
        if (rx_byte == sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase_next = (rx_byte == sync_second) ? PH_ID_LO : PH_SYNC1;
      end
      PH_ID_LO: begin
        id_word_next[7:0] = rx_byte;
        phase_next        = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_word_next[15:8] = rx_byte;
        phase_next         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_word_next[7:0] = rx_byte;
        phase_next            = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_word_next[15:8] = rx_byte;
        pos_next               = '0;
        phase_next             = PH_SPARE_LO;
      end
      PH_SPARE_LO: begin
        spare_word_next[7:0] = rx_byte;
        phase_next           = PH_SPARE_HI;
      end
      PH_SPARE_HI: begin
        spare_word_next[15:8] = rx_byte;
        phase_next            = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        check_word_next[7:0] = rx_byte;
        phase_next           = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        check_word_next[15:8] = rx_byte;
        phase_next            = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (in_payload) begin
          res.payload_strobe = 1'b1;
          res.payload_byte   = rx_byte;
          res.payload_index  = INDEX_W'(pos);
          pos_next           = pos_wrap;
        end else begin
          // first trailing checksum byte, dropped
          pos_next   = '0;
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        res.frame_done   = 1'b1;
        res.header_good  = good;
        res.message_kind = good ? kind_of(id_word) : KIND_UNKNOWN;
        res.message_id   = id_word;
        res.word_count   = length_word;
        phase_next       = PH_SYNC1;
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC1;
      id_word     <= '0;
      length_word <= '0;
      spare_word  <= '0;
      check_word  <= '0;
      pos         <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      id_word     <= id_word_next;
      length_word <= length_word_next;
      spare_word  <= spare_word_next;
      check_word  <= check_word_next;
      pos         <= pos_next;
    end
  end

  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_done |-> !res.payload_strobe &&
      (res.header_good || res.message_kind == KIND_UNKNOWN))
    else $error("frame end item carries payload or a kind without a good header");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    fire && res.payload_strobe |=> pos == '0 || pos == POS_W'($past(pos) + 1'b1))
    else $error("payload position did not advance by one or wrap");

endmodule

/* rtl/bfr_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
module bfr_out_buf import bfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  result_t   din,
  output logic      can_take,
  bfr_res_if.source result
);

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;
  logic    pop;

  assign can_take = !skid_valid;
  assign pop      = main_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : din;
    end else if (!main_valid) begin
      main_data <= din;
    end else if (push) begin
      skid_data <= din;
    end
  end

  assign result.valid          = main_valid;
  assign result.payload_strobe = main_data.payload_strobe;
  assign result.payload_byte   = main_data.payload_byte;
  assign result.payload_index  = main_data.payload_index;
  assign result.frame_done     = main_data.frame_done;
  assign result.header_good    = main_data.header_good;
  assign result.message_kind   = main_data.message_kind;
  assign result.message_id     = main_data.message_id;
  assign result.word_count     = main_data.word_count;

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(main_valid && !result.ready && push))
    else $error("skid entry filled without a stalled output");

endmodule

/* rtl/binary_frame_receiver_unit.sv */
// Top level of the binary frame receiver: config registers, parser, result buffer.
//
// Byte-serial frame receiver. It hunts for the two sync bytes (config
// registers 0 and 1, reset 0xFF and 0x81), captures the little-endian id,
// word count, spare and header check words, then streams 2*word_count
// payload bytes out with their position (wrapping at PAYLOAD_BYTES). The two
// trailing payload checksum bytes are swallowed unchecked; the second one
// produces the frame-done item with the header check result and message kind.
// Every accepted byte yields exactly one result item. Throughput is one byte
// per clock while rx.ready is high: the parser state machine updates in the
// accept cycle and the result lands in a two-entry output buffer, so rx stays
// ready while one result waits downstream. Each result is registered there.
// rx.ready drops only when both buffer entries are full. Payload is not
// stored, so there is no memory and no clearing pass after reset. Config
// writes are always accepted (cfg.ready is tied high); indexes past the
// register list are ignored. Write config only while the block is idle.
module binary_frame_receiver_unit import bfr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bfr_rx_if.sink    rx,
  bfr_res_if.source result,
  bfr_cfg_if.sink   cfg
);

  logic [7:0] sync_first_reg, sync_second_reg;
  logic       rx_fire;
  logic       buf_can_take;
  result_t    parse_res;

  // Config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first_reg  <= SYNC_FIRST_RST;
      sync_second_reg <= SYNC_SECOND_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SYNC_FIRST:  sync_first_reg  <= cfg.data;
        REG_SYNC_SECOND: sync_second_reg <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input handshake: take a byte whenever the buffer has a free slot
  assign rx.ready = buf_can_take;
  assign rx_fire  = rx.valid && buf_can_take;

  bfr_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (rx_fire),
    .rx_byte    (rx.in_byte),
    .sync_first (sync_first_reg),
    .sync_second(sync_second_reg),
    .res        (parse_res)
  );

  bfr_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (rx_fire),
    .din     (parse_res),
    .can_take(buf_can_take),
    .result  (result)
  );

endmodule

/* tb/frame_tracker_pkg.sv */
// Frame tracker class: predicts receiver results and checks the result items.
package frame_tracker_pkg;
  import bfr_pkg::*;

  class frame_tracker;
    // sync register copies
    logic [7:0]  sync_lo;
    logic [7:0]  sync_hi;
    // receive state
    phase_t      phase;
    logic [15:0] id_w;
    logic [15:0] len_w;
    logic [15:0] spare_w;
    logic [15:0] chk_w;
    int unsigned pos;
    logic [15:0] known_ids[7];

    result_t     expected[$];
    int          errors;
    int          frames;
    int          good_frames;
    int          payload_seen;

    function new();
      sync_lo      = SYNC_FIRST_RST;
      sync_hi      = SYNC_SECOND_RST;
      phase        = PH_SYNC1;
      id_w         = '0;
      len_w        = '0;
      spare_w      = '0;
      chk_w        = '0;
      pos          = 0;
      known_ids    = '{ID_KIND1, ID_KIND2, ID_KIND3, ID_KIND4, ID_KIND5, ID_KIND6, ID_KIND7};
      errors       = 0;
      frames       = 0;
      good_frames  = 0;
      payload_seen = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == REG_SYNC_FIRST) sync_lo = val;
      else if (idx == REG_SYNC_SECOND) sync_hi = val;
    endfunction

    function logic [2:0] kind_code(logic [15:0] id);
      for (int k = 0; k < 7; k++)
        if (known_ids[k] == id) return 3'(k + 1);
      return KIND_UNKNOWN;
    endfunction

    // Advance the receive state by one byte and queue the item it produces.
    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [15:0] sum;
      logic [15:0] want_chk;
      r = '0;
      case (phase)
        PH_SYNC1:    if (b == sync_lo) phase = PH_SYNC2;
        PH_SYNC2:    phase = (b == sync_hi) ? PH_ID_LO : PH_SYNC1;
        PH_ID_LO:    begin id_w[7:0]     = b; phase = PH_ID_HI;    end
        PH_ID_HI:    begin id_w[15:8]    = b; phase = PH_LEN_LO;   end
        PH_LEN_LO:   begin len_w[7:0]    = b; phase = PH_LEN_HI;   end
        PH_LEN_HI:   begin len_w[15:8]   = b; pos = 0; phase = PH_SPARE_LO; end
        PH_SPARE_LO: begin spare_w[7:0]  = b; phase = PH_SPARE_HI; end
        PH_SPARE_HI: begin spare_w[15:8] = b; phase = PH_CHK_LO;   end
        PH_CHK_LO:   begin chk_w[7:0]    = b; phase = PH_CHK_HI;   end
        PH_CHK_HI:   begin chk_w[15:8]   = b; phase = PH_PAYLOAD;  end
        PH_PAYLOAD: begin
          if (pos < {len_w, 1'b0}) begin
            r.payload_strobe = 1'b1;
            r.payload_byte   = b;
            r.payload_index  = pos[INDEX_W-1:0];
            pos++;
            if (pos >= PAYLOAD_BYTES_DEF) pos = 0;
            payload_seen++;
          end else begin
            // first trailing checksum byte, swallowed
            pos   = 0;
            phase = PH_TRAILER;
          end
        end
        default: begin
          sum           = {sync_hi, sync_lo} + id_w + len_w + spare_w;
          want_chk      = -sum;
          r.frame_done  = 1'b1;
          r.header_good = (want_chk == chk_w);
          r.message_kind = r.header_good ? kind_code(id_w) : KIND_UNKNOWN;
          r.message_id  = id_w;
          r.word_count  = len_w;
          phase         = PH_SYNC1;
          frames++;
          if (r.header_good) good_frames++;
        end
      endcase
      expected.push_back(r);
    endfunction

    function void report(string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void cmp(string field, int unsigned got, int unsigned want, int seq);
      if (got != want)
        report($sformatf("item %0d %s got 0x%0h want 0x%0h", seq, field, got, want));
    endfunction

    function void check_item(result_t got, int seq);
      result_t want;
      if (expected.size() == 0) begin
        report($sformatf("item %0d arrived with nothing pending", seq));
        return;
      end
      want = expected.pop_front();
      cmp("payload_strobe", got.payload_strobe, want.payload_strobe, seq);
      cmp("payload_byte",   got.payload_byte,   want.payload_byte,   seq);
      cmp("payload_index",  got.payload_index,  want.payload_index,  seq);
      cmp("frame_done",     got.frame_done,     want.frame_done,     seq);
      cmp("header_good",    got.header_good,    want.header_good,    seq);
      cmp("message_kind",   got.message_kind,   want.message_kind,   seq);
      cmp("message_id",     got.message_id,     want.message_id,     seq);
      cmp("word_count",     got.word_count,     want.word_count,     seq);
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// Top-level testbench for the binary frame receiver.
//
// Bytes are pushed through the rx channel one item at a time; every accepted
// byte is fed to the frame tracker, which keeps its own copy of the receive
// state and queues the one result item it expects. Result items are checked
// in order against that queue. The run goes through several sync settings,
// changing them only once the block has drained.
module tb;
  import bfr_pkg::*;
  import frame_tracker_pkg::*;

  localparam int PHASE_ITEMS = 115;    // frame bytes per sync setting
  localparam int QUIET_AFTER = 560;    // no idling from here on
  localparam int WRAP_BYTES  = 520;    // long enough to wrap the index once
  localparam int STALL_LIMIT = 2000;   // cycles without any handshake
  // first index past the register list; the block must ignore it
  localparam logic [7:0] REG_UNUSED = REG_SYNC_SECOND + 8'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfr_rx_if  rx();
  bfr_res_if result();
  bfr_cfg_if cfg();

  binary_frame_receiver_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result),
    .cfg    (cfg)
  );

  frame_tracker tracker = new();

  int frame_bytes = 0;   // bytes sent as part of a frame
  int settings    = 1;   // sync settings visited, reset value included
  int result_seq  = 0;
  int src_odds    = 0;   // 0: sender never idles, else 1-in-N chance
  int sink_odds   = 0;
  bit quiet       = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  // Everything driven known from time zero.
  initial begin
    rx.valid     = 1'b0;
    rx.in_byte   = '0;
    result.ready = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
  end

  // Result sink: ready drops in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && sink_odds != 0 && $urandom_range(0, sink_odds - 1) == 0) begin
      result.ready <= 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // All handshakes are observed at the rising edge, before the block updates.
  // The result check comes first; a byte accepted at this edge cannot have
  // produced an item yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) begin
        tracker.check_item('{payload_strobe: result.payload_strobe,
                             payload_byte:   result.payload_byte,
                             payload_index:  result.payload_index,
                             frame_done:     result.frame_done,
                             header_good:    result.header_good,
                             message_kind:   result.message_kind,
                             message_id:     result.message_id,
                             word_count:     result.word_count}, result_seq);
        result_seq++;
      end
      if (rx.valid && rx.ready) tracker.note_byte(rx.in_byte);
      if (cfg.valid && cfg.ready) tracker.write_reg(cfg.index, cfg.data);
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((rx.valid && rx.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: stalled for %0d cycles, %0d items pending", idle_cycles,
                 tracker.expected.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drive tasks are entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && src_odds != 0 && $urandom_range(0, src_odds - 1) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.in_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_sync(input logic [7:0] first_b, input logic [7:0] second_b);
    write_reg(REG_SYNC_FIRST, first_b);
    write_reg(REG_SYNC_SECOND, second_b);
    settings++;
  endtask

  // Wait until every expected item has come back.
  task automatic drain();
    rx.valid <= 1'b0;
    @(negedge clk);
    while (tracker.expected.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] v);
    logic [7:0] b;
    b = 8'($urandom);
    return (b == v) ? ~b : b;
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  // Header built from the sync registers currently in force; body is the
  // payload plus trailer byte count (or just a long stream for a stuck frame).
  task automatic send_frame(input logic [15:0] id, input logic [15:0] wc,
                            input logic [15:0] spare, input bit hdr_ok, input int body);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  head[10];
    sum = {tracker.sync_hi, tracker.sync_lo} + id + wc + spare;
    chk = -sum;
    if (!hdr_ok) chk = chk ^ 16'($urandom_range(1, 65535));
    head = '{tracker.sync_lo, tracker.sync_hi, id[7:0], id[15:8], wc[7:0], wc[15:8],
             spare[7:0], spare[15:8], chk[7:0], chk[15:8]};
    foreach (head[i]) send_byte(head[i]);
    repeat (body) send_byte(8'($urandom));
    frame_bytes += 10 + body;
  endtask

  // Mostly short well-formed frames; now and then line noise or a false start
  // ahead of them. Lengths stay below the buffer so the frame completes.
  task automatic random_frame();
    logic [15:0] id;
    logic [15:0] wc;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      wc = 16'($urandom_range(0, 6));
    else if (pick < 95) wc = 16'($urandom_range(7, 40));
    else                wc = 16'($urandom_range(200, 255));
    if ($urandom_range(0, 1)) id = tracker.known_ids[$urandom_range(0, 6)];
    else                      id = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      // noise that cannot start a frame
      repeat ($urandom_range(1, 4)) send_byte(byte_other_than(tracker.sync_lo));
    end else if (pick == 3) begin
      // first sync byte followed by a wrong second one
      send_byte(tracker.sync_lo);
      send_byte(byte_other_than(tracker.sync_hi));
    end
    send_frame(id, wc, 16'($urandom), $urandom_range(0, 4) != 0, 2 * wc + 2);
  endtask

  initial begin
    int stop;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset sync values, known id with an empty payload and good
    // header, then a one-word payload with every id bit set and a bad header.
    send_frame(ID_KIND1, 16'h0000, 16'hFFFF, 1'b1, 2);
    send_frame(16'hFFFF, 16'h0001, 16'h0000, 1'b0, 4);

    // Random frames under a series of sync settings, extremes first.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: ;
        1: set_sync(8'h00, 8'h00);
        2: set_sync(8'hFF, 8'hFF);
        3: begin
          set_sync(8'h00, 8'hFF);
          write_reg(REG_UNUSED, 8'($urandom));
        end
        default: set_sync(8'($urandom), 8'($urandom));
      endcase
      src_odds  = pick_odds();
      sink_odds = pick_odds();
      stop = frame_bytes + PHASE_ITEMS;
      while (frame_bytes < stop) begin
        if (frame_bytes >= QUIET_AFTER) quiet = 1'b1;
        random_frame();
      end
    end

    // Last: a length the buffer cannot hold. The block never leaves the
    // payload phase, so this comes at the very end; the index wraps once.
    quiet = 1'b1;
    send_frame(16'($urandom), 16'($urandom_range(256, 65535)), 16'($urandom), 1'b1,
               WRAP_BYTES);
    drain();
    repeat (8) @(posedge clk);

    $display("tb: %0d frame bytes under %0d sync settings, %0d result items checked",
             frame_bytes, settings, result_seq);
    $display("tb: %0d frames closed (%0d good header), %0d payload bytes, %0d mismatches",
             tracker.frames, tracker.good_frames, tracker.payload_seen, tracker.errors);
    if (tracker.errors == 0 && tracker.expected.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
rtl/bfr_pkg.sv
rtl/bfr_ifs.sv
rtl/bfr_parser.sv
rtl/bfr_out_buf.sv
rtl/binary_frame_receiver_unit.sv
tb/frame_tracker_pkg.sv
tb/tb.sv
